// ===== hdl/b93_pkg.sv =====
// ----------------------------------------------------------------------------
// b93_pkg
// Shared types, constants and the symbol alphabet for the base-93 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b93_pkg;

    // Request codes
    typedef enum logic {
        REQ_DATA  = 1'b0,
        REQ_FLUSH = 1'b1
    } t_req;

    typedef logic [6:0]  t_char;
    typedef logic [20:0] t_queue;
    typedef logic [4:0]  t_count;
    typedef logic [13:0] t_val;

    localparam int unsigned SYM_COUNT   = 93;
    localparam int unsigned SPLIT_LIMIT = 456;
    localparam int unsigned SHORT_BITS  = 13;
    localparam int unsigned LONG_BITS   = 14;
    localparam int unsigned TAIL_LIMIT  = 92;
    localparam int unsigned TAIL_BITS   = 7;
    localparam int unsigned BYTE_BITS   = 8;

    // floor(v / 93) == (v * DIV_MULT) >> DIV_SHIFT for every 14-bit v
    localparam int unsigned DIV_SHIFT = 21;
    localparam int unsigned DIV_MULT  = ((1 << DIV_SHIFT) + SYM_COUNT - 1) / SYM_COUNT;

    // Alphabet lookup: symbol index (0..92) to ASCII code
    function automatic t_char sym_char(input logic [6:0] idx);
        t_char c;
        c = 7'h20;
        if (idx < 7'd26) begin
            c = 7'(7'h41 + idx);
        end else if (idx < 7'd52) begin
            c = 7'(7'h61 + (idx - 7'd26));
        end else if (idx < 7'd62) begin
            c = 7'(7'h30 + (idx - 7'd52));
        end else begin
            unique case (idx)
                7'd62:   c = 7'h21;
                7'd63:   c = 7'h23;
                7'd64:   c = 7'h24;
                7'd65:   c = 7'h25;
                7'd66:   c = 7'h26;
                7'd67:   c = 7'h27;
                7'd68:   c = 7'h28;
                7'd69:   c = 7'h29;
                7'd70:   c = 7'h2A;
                7'd71:   c = 7'h2B;
                7'd72:   c = 7'h2C;
                7'd73:   c = 7'h2D;
                7'd74:   c = 7'h2E;
                7'd75:   c = 7'h2F;
                7'd76:   c = 7'h3A;
                7'd77:   c = 7'h3B;
                7'd78:   c = 7'h3C;
                7'd79:   c = 7'h3D;
                7'd80:   c = 7'h3E;
                7'd81:   c = 7'h3F;
                7'd82:   c = 7'h40;
                7'd83:   c = 7'h5B;
                7'd84:   c = 7'h5D;
                7'd85:   c = 7'h5E;
                7'd86:   c = 7'h5F;
                7'd87:   c = 7'h60;
                7'd88:   c = 7'h7B;
                7'd89:   c = 7'h7C;
                7'd90:   c = 7'h7D;
                7'd91:   c = 7'h7E;
                default: c = 7'h20;
            endcase
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/b93_in_if.sv =====
// ----------------------------------------------------------------------------
// b93_in_if
// Request channel: data byte or flush request, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface b93_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  in_byte;

    modport source (output valid, output req_type, output in_byte, input ready);
    modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/b93_out_if.sv =====
// ----------------------------------------------------------------------------
// b93_out_if
// Character channel: one encoded symbol per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface b93_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  out_char;
    logic        last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hdl/base93_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// base93_stream_encoder
// Streaming base-93 encoder: packs bytes into 13/14-bit groups, emits two
// alphabet characters per group, and drains the tail on a flush request.
// ----------------------------------------------------------------------------
// Path: a beat's first character leaves through the stage A and stage B registers.
// Throughput: one character per cycle while the output is ready; a byte that
//   closes a group yields two characters on the single output port.
// The bit queue updates in the accept cycle; the divide-by-93 multiplier
//   sits in the register-to-register path between the two stages.
// Reset (i_rst_n low, synchronous): queue and bit count cleared, both stages empty.
`default_nettype none

module base93_stream_encoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    b93_in_if.sink      i_in,
    b93_out_if.source   o_out
);

    // Encoder state
    b93_pkg::t_queue r_queue, n_queue;
    b93_pkg::t_count r_count, n_count;

    // Stage A: value to split into characters
    logic            r_a_valid, n_a_valid;
    b93_pkg::t_val   r_a_val,   n_a_val;
    logic            r_a_two,   n_a_two;

    // Stage B: character pair being sent
    logic            r_b_valid, n_b_valid;
    logic            r_b_sel,   n_b_sel;
    logic            r_b_two,   n_b_two;
    b93_pkg::t_char  r_b_c0,    n_b_c0;
    b93_pkg::t_char  r_b_c1,    n_b_c1;

    logic            in_acc;
    logic            b_done;
    logic            b_free;
    logic            a_move;

    // Append and group selection
    logic [4:0]      sh;
    b93_pkg::t_queue app;
    logic [4:0]      app_cnt;

    // Divide by 93
    logic [28:0]     prod;
    logic [7:0]      quo;
    logic [14:0]     quo93;
    logic [6:0]      rem;
    logic [6:0]      quo_mod;

    // Handshake
    assign b_done = r_b_valid && o_out.ready && (r_b_sel || !r_b_two);
    assign b_free = !r_b_valid || b_done;
    assign a_move = r_a_valid && b_free;
    assign i_in.ready = !r_a_valid || b_free;
    assign in_acc = i_in.valid && i_in.ready;

    assign o_out.valid       = r_b_valid;
    assign o_out.out_char    = r_b_sel ? r_b_c1 : r_b_c0;
    assign o_out.last_of_run = r_b_sel || !r_b_two;

    // Byte append into the queue
    always_comb begin
        sh      = (r_count > 5'(b93_pkg::SHORT_BITS)) ? 5'(b93_pkg::SHORT_BITS) : r_count;
        app     = r_queue | (b93_pkg::t_queue'(i_in.in_byte) << sh);
        app_cnt = 5'(sh + 5'(b93_pkg::BYTE_BITS));
    end

    // Divide/modulo by 93 via reciprocal multiply
    always_comb begin
        prod    = {15'd0, r_a_val} * 29'(b93_pkg::DIV_MULT);
        quo     = prod[28:21];
        quo93   = {7'd0, quo} * 15'(b93_pkg::SYM_COUNT);
        rem     = 7'(r_a_val - quo93[13:0]);
        quo_mod = (quo >= 8'(b93_pkg::SYM_COUNT)) ? 7'(quo - 8'(b93_pkg::SYM_COUNT))
                                                  : quo[6:0];
    end

    // Next state for queue and stage A
    always_comb begin
        n_queue   = r_queue;
        n_count   = r_count;
        n_a_valid = r_a_valid && !a_move;
        n_a_val   = r_a_val;
        n_a_two   = r_a_two;
        if (in_acc) begin
            if (b93_pkg::t_req'(i_in.req_type) == b93_pkg::REQ_FLUSH) begin
                n_queue   = '0;
                n_count   = '0;
                n_a_valid = (r_count != 5'd0);
                n_a_val   = r_queue[13:0];
                n_a_two   = (r_count > 5'(b93_pkg::TAIL_BITS))
                         || (r_queue > 21'(b93_pkg::TAIL_LIMIT));
            end else if (app_cnt > 5'(b93_pkg::SHORT_BITS)) begin
                n_a_valid = 1'b1;
                n_a_two   = 1'b1;
                if (app[12:0] > 13'(b93_pkg::SPLIT_LIMIT)) begin
                    n_a_val = {1'b0, app[12:0]};
                    n_queue = app >> b93_pkg::SHORT_BITS;
                    n_count = 5'(app_cnt - 5'(b93_pkg::SHORT_BITS));
                end else begin
                    n_a_val = app[13:0];
                    n_queue = app >> b93_pkg::LONG_BITS;
                    n_count = 5'(app_cnt - 5'(b93_pkg::LONG_BITS));
                end
            end else begin
                n_queue = app;
                n_count = app_cnt;
            end
        end
    end

    // Next state for stage B
    always_comb begin
        n_b_valid = r_b_valid && !b_done;
        n_b_sel   = r_b_sel;
        n_b_two   = r_b_two;
        n_b_c0    = r_b_c0;
        n_b_c1    = r_b_c1;
        if (r_b_valid && o_out.ready && !r_b_sel && r_b_two) begin
            n_b_sel = 1'b1;
        end
        if (a_move) begin
            n_b_valid = 1'b1;
            n_b_sel   = 1'b0;
            n_b_two   = r_a_two;
            n_b_c0    = b93_pkg::sym_char(rem);
            n_b_c1    = b93_pkg::sym_char(quo_mod);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue   <= '0;
            r_count   <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_b_sel   <= 1'b0;
        end else begin
            r_queue   <= n_queue;
            r_count   <= n_count;
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
            r_b_sel   <= n_b_sel;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_a_val <= n_a_val;
        r_a_two <= n_a_two;
        r_b_two <= n_b_two;
        r_b_c0  <= n_b_c0;
        r_b_c1  <= n_b_c1;
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 5'(b93_pkg::SHORT_BITS))
        else $error("bit count above 13");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.req_type |=> (r_count == 5'd0) && (r_queue == '0))
        else $error("flush left bits in queue");

    a_a_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !b_free |=> r_a_valid && $stable(r_a_val) && $stable(r_a_two))
        else $error("stage A lost its value while stalled");

    a_second_only_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_sel |-> r_b_two)
        else $error("second character sent for a single-character group");

    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.last_of_run |=> o_out.valid && r_b_sel)
        else $error("pair not completed after first character");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for base93_stream_encoder. A queue of data and flush
// beats feeds a randomly idling driver; a predictor packs the same bits into
// 13/14-bit groups and queues the characters it expects, which the output
// monitor checks in order against every character the encoder sends.
// ----------------------------------------------------------------------------

module testbench;

    typedef struct packed {
        b93_pkg::t_req kind;
        logic [7:0]    data;
    } t_req_beat;

    typedef struct packed {
        b93_pkg::t_char ch;
        logic           is_last;
    } t_char_beat;

    localparam int unsigned LONG_STALL = 120;
    localparam int unsigned TAIL_WAIT  = 8;

    // Symbol table in index order; octal escape is the backtick
    string b93_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789!#$%&'()*+,-./:;<=>?@[]^_\140{|}~ ";

    logic i_clk;
    logic i_rst_n;

    b93_in_if  in_bus ();
    b93_out_if out_bus ();

    base93_stream_encoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Pending request beats and expected characters
    t_req_beat  req_fifo[$];
    t_char_beat expected_chars[$];

    // Predictor state
    b93_pkg::t_queue enc_bits;
    b93_pkg::t_count enc_count;

    logic calm;
    logic in_beat;
    int   stall_asked;
    int   mismatches;
    int   beats_in;
    int   chars_out;
    int   flush_beats;
    int   short_groups;
    int   long_groups;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic b93_pkg::t_char symbol_at(input int unsigned idx);
        return b93_pkg::t_char'(b93_alphabet[idx % b93_pkg::SYM_COUNT]);
    endfunction

    function automatic void expect_char(input int unsigned idx, input logic is_last);
        t_char_beat cb;
        cb.ch      = symbol_at(idx);
        cb.is_last = is_last;
        expected_chars.push_back(cb);
    endfunction

    // Advance the bit queue by one beat and queue the characters it yields
    function automatic void predict_encoder(input t_req_beat rb);
        b93_pkg::t_val group;
        logic          two_chars;
        int unsigned   bits_now;
        bits_now = enc_bits;
        if (rb.kind == b93_pkg::REQ_DATA) begin
            enc_bits  = enc_bits | (b93_pkg::t_queue'(rb.data) << enc_count);
            enc_count = enc_count + b93_pkg::t_count'(b93_pkg::BYTE_BITS);
            if (enc_count > b93_pkg::SHORT_BITS) begin
                if (enc_bits[12:0] > b93_pkg::SPLIT_LIMIT) begin
                    group     = {1'b0, enc_bits[12:0]};
                    enc_bits  = enc_bits >> b93_pkg::SHORT_BITS;
                    enc_count = enc_count - b93_pkg::t_count'(b93_pkg::SHORT_BITS);
                    short_groups++;
                end else begin
                    group     = enc_bits[13:0];
                    enc_bits  = enc_bits >> b93_pkg::LONG_BITS;
                    enc_count = enc_count - b93_pkg::t_count'(b93_pkg::LONG_BITS);
                    long_groups++;
                end
                expect_char(group % b93_pkg::SYM_COUNT, 1'b0);
                expect_char((group / b93_pkg::SYM_COUNT) % b93_pkg::SYM_COUNT, 1'b1);
            end
        end else begin
            flush_beats++;
            if (enc_count != 0) begin
                two_chars = (enc_count > b93_pkg::TAIL_BITS)
                         || (bits_now > b93_pkg::TAIL_LIMIT);
                expect_char(bits_now % b93_pkg::SYM_COUNT, !two_chars);
                if (two_chars) begin
                    expect_char((bits_now / b93_pkg::SYM_COUNT) % b93_pkg::SYM_COUNT,
                                1'b1);
                end
            end
            enc_bits  = '0;
            enc_count = '0;
        end
    endfunction

    function automatic void queue_beat(input b93_pkg::t_req kind, input logic [7:0] data);
        t_req_beat rb;
        rb.kind = kind;
        rb.data = data;
        req_fifo.push_back(rb);
    endfunction

    // Mostly data bytes; small bytes push the group value low so the
    // 14-bit path shows up often, flushes come now and then
    function automatic void queue_random(input int count);
        int unsigned pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                queue_beat(b93_pkg::REQ_FLUSH, 8'($urandom));
            end else if (pick < 30) begin
                queue_beat(b93_pkg::REQ_DATA, 8'($urandom_range(0, 3)));
            end else begin
                queue_beat(b93_pkg::REQ_DATA, 8'($urandom));
            end
        end
    endfunction

    // Request driver: new beat only once the last one was taken
    int unsigned src_gap;
    t_req_beat   next_beat;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_beat) begin
            if (src_gap > 0) begin
                src_gap--;
                in_bus.valid <= 1'b0;
            end else if (req_fifo.size() == 0) begin
                in_bus.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                src_gap = $urandom_range(1, 4) - 1;
                in_bus.valid <= 1'b0;
            end else begin
                next_beat = req_fifo.pop_front();
                in_bus.req_type <= next_beat.kind;
                in_bus.in_byte  <= next_beat.data;
                in_bus.valid    <= 1'b1;
            end
        end
    end

    // Character sink: short random stalls plus the requested long hold-off
    int unsigned snk_gap;
    int unsigned stall_left;
    int          stall_done;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_bus.ready <= 1'b0;
        end else if (stall_done != stall_asked) begin
            stall_done++;
            stall_left = LONG_STALL - 1;
            out_bus.ready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            out_bus.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            snk_gap = $urandom_range(1, 4) - 1;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    // Monitor: predict on each accepted request, check each character
    t_char_beat want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_beat <= 1'b0;
        end else begin
            in_beat <= in_bus.valid && in_bus.ready;
            if (in_bus.valid && in_bus.ready) begin
                beats_in++;
                predict_encoder('{kind: b93_pkg::t_req'(in_bus.req_type),
                                  data: in_bus.in_byte});
            end
            if (out_bus.valid && out_bus.ready) begin
                chars_out++;
                if (expected_chars.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected char %h last %b, nothing expected",
                             $realtime, out_bus.out_char, out_bus.last_of_run);
                end else begin
                    want = expected_chars.pop_front();
                    if (out_bus.out_char !== want.ch) begin
                        mismatches++;
                        $display("%0t: out_char expected %h, actual %h",
                                 $realtime, want.ch, out_bus.out_char);
                    end
                    if (out_bus.last_of_run !== want.is_last) begin
                        mismatches++;
                        $display("%0t: last_of_run expected %b, actual %b",
                                 $realtime, want.is_last, out_bus.last_of_run);
                    end
                end
            end
        end
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("FAIL base93_stream_encoder");
        $finish;
    end

    // Stimulus sequence
    initial begin
        int base;
        in_bus.valid    = 1'b0;
        in_bus.req_type = b93_pkg::REQ_DATA;
        in_bus.in_byte  = 8'h00;
        out_bus.ready   = 1'b0;
        i_rst_n         = 1'b0;
        in_beat         = 1'b0;
        calm            = 1'b0;
        enc_bits        = '0;
        enc_count       = '0;
        stall_asked     = 0;
        stall_done      = 0;
        src_gap         = 0;
        snk_gap         = 0;
        stall_left      = 0;
        mismatches      = 0;
        beats_in        = 0;
        chars_out       = 0;
        flush_beats     = 0;
        short_groups    = 0;
        long_groups     = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: flush on empty queue, all-zero and all-one bytes,
        // one-byte tail, 7-bit tail above 92, split limit on both sides
        queue_beat(b93_pkg::REQ_FLUSH, 8'hA5);
        queue_beat(b93_pkg::REQ_DATA, 8'h00);
        queue_beat(b93_pkg::REQ_DATA, 8'h00);
        queue_beat(b93_pkg::REQ_FLUSH, 8'h5A);
        queue_beat(b93_pkg::REQ_DATA, 8'hFF);
        queue_beat(b93_pkg::REQ_DATA, 8'hFF);
        queue_beat(b93_pkg::REQ_FLUSH, 8'hFF);
        queue_beat(b93_pkg::REQ_DATA, 8'hFF);
        queue_beat(b93_pkg::REQ_FLUSH, 8'h00);
        for (int k = 0; k < 9; k++) begin
            queue_beat(b93_pkg::REQ_DATA, 8'hFF);
        end
        queue_beat(b93_pkg::REQ_FLUSH, 8'h00);
        queue_beat(b93_pkg::REQ_DATA, 8'hC8);
        queue_beat(b93_pkg::REQ_DATA, 8'h01);
        queue_beat(b93_pkg::REQ_FLUSH, 8'h00);
        queue_beat(b93_pkg::REQ_DATA, 8'hC9);
        queue_beat(b93_pkg::REQ_DATA, 8'h01);
        queue_beat(b93_pkg::REQ_FLUSH, 8'h00);

        // Sender waits here until every character has come back
        while (req_fifo.size() != 0 || in_bus.valid || expected_chars.size() != 0) begin
            @(posedge i_clk);
        end

        // Random with a long sink hold-off while requests keep coming
        base = beats_in;
        queue_random(600);
        while (beats_in < base + 200) begin
            @(posedge i_clk);
        end
        stall_asked++;
        while (req_fifo.size() != 0 || in_bus.valid || expected_chars.size() != 0) begin
            @(posedge i_clk);
        end

        queue_random(600);
        while (req_fifo.size() != 0 || in_bus.valid || expected_chars.size() != 0) begin
            @(posedge i_clk);
        end

        // Closing stretch at full rate
        calm = 1'b1;
        queue_random(550);
        queue_beat(b93_pkg::REQ_FLUSH, 8'h3C);
        while (req_fifo.size() != 0 || in_bus.valid || expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("Sent %0d request beats (%0d flushes), checked %0d characters.",
                 beats_in, flush_beats, chars_out);
        $display("Groups: %0d on the 13-bit path, %0d on the 14-bit path.",
                 short_groups, long_groups);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("PASS base93_stream_encoder");
        end else begin
            $display("FAIL base93_stream_encoder");
        end
        $finish;
    end

endmodule
